FILE: design/assert_macros.svh
// Assertion shorthands shared by the filter's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define CSF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define CSF_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

FILE: design/csf_pkg.sv
package csf_pkg;

   localparam logic [1:0] CLS_INVALID = 2'd0;
   localparam logic [1:0] CLS_IMAGE   = 2'd1;
   localparam logic [1:0] CLS_ANIM    = 2'd2;
   localparam logic [1:0] CLS_META    = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOXFORM = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   localparam logic [1:0] CSR_STRIP_EVERYTHING   = 2'd0;
   localparam logic [1:0] CSR_STRIP_ANIMATION    = 2'd1;
   localparam logic [1:0] CSR_PROTECT_EVERYTHING = 2'd2;

   localparam logic [31:0] TAG_TRNS = 32'h74524E53;
   localparam logic [31:0] TAG_ACTL = 32'h6163544C;
   localparam logic [31:0] TAG_FCTL = 32'h6663544C;
   localparam logic [31:0] TAG_FDAT = 32'h66644154;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] tag;
   } req_type;

   typedef struct packed {
      logic       strip_it;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic strip_everything;
      logic strip_animation;
      logic protect_everything;
   } cfg_type;

   // One classified item waiting for the set lookup.
   typedef struct packed {
      logic        query;
      logic        to_protect;
      logic [31:0] tag;
      logic [1:0]  cls;
   } entry_type;

   function automatic logic [1:0] classify(input logic [31:0] tag);
      logic       letters;
      logic [7:0] b;
      logic [7:0] first;
      letters = 1'b1;
      for (int k = 0; k < 4; k++) begin
         b = tag[8*k +: 8];
         if (!(b inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
            letters = 1'b0;
         end
      end
      first = tag[31:24];
      if (!letters) begin
         return CLS_INVALID;
      end else if ((first inside {[8'h41:8'h5A]}) || tag == TAG_TRNS) begin
         return CLS_IMAGE;
      end else if (tag == TAG_ACTL || tag == TAG_FCTL || tag == TAG_FDAT) begin
         return CLS_ANIM;
      end else begin
         return CLS_META;
      end
   endfunction

endpackage

FILE: design/csf_ram.sv
module csf_ram
   #(parameter int WIDTH = 32,
     parameter int DEPTH = 32,
     localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/csf_front.sv
module csf_front
   import csf_pkg::*;
   (
   input  logic      start,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      busy,
   output logic      push,
   output entry_type push_entry
   );

   assign busy = q_full;
   assign push = start && !q_full;

   // Bit 1 of func selects a query, so the unused code also queries.
   always_comb begin
      push_entry.query      = req_data.func[1];
      push_entry.to_protect = req_data.func[0];
      push_entry.tag        = req_data.tag;
      push_entry.cls        = classify(req_data.tag);
   end

endmodule

FILE: design/csf_queue.sv
`include "assert_macros.svh"

module csf_queue
   import csf_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
   );

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CSF_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && full)
   `CSF_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && empty)

endmodule

FILE: design/csf_back.sv
`include "assert_macros.svh"

module csf_back
   import csf_pkg::*;
   #(parameter int SET_DEPTH = 32,
     localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
     localparam int CW = $clog2(SET_DEPTH + 1))
   (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      pop,
   output logic      rsp_strobe,
   output rsp_type   rsp_data
   );

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(SET_DEPTH);

   logic [1:0]    state_ff, state_in;
   entry_type     item_ff, item_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          hit_s_ff, hit_s_in;
   logic          hit_p_ff, hit_p_in;
   logic [CW-1:0] su_ff, su_in;
   logic [CW-1:0] pu_ff, pu_in;
   logic          meta_ff, meta_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [CW-1:0] limit;
   logic          hit_s_now;
   logic          hit_p_now;
   logic          hit_sel;
   logic [CW-1:0] used_sel;
   logic          s_we;
   logic          p_we;
   logic [31:0]   s_rdata;
   logic [31:0]   p_rdata;

   csf_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_strip_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (su_ff[AW-1:0]),
      .wdata (item_ff.tag),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (s_rdata)
   );

   csf_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_protect_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (pu_ff[AW-1:0]),
      .wdata (item_ff.tag),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (p_rdata)
   );

   // Both sets are scanned together, one entry a cycle, as far as the longer one.
   assign limit = (su_ff > pu_ff) ? su_ff : pu_ff;

   // Read data arrives in the cycle after its address; entries past a set's count
   // are stale and must not match.
   assign hit_s_now = hit_s_ff ||
                      (rd_valid_ff && rd_idx_ff < su_ff && s_rdata == item_ff.tag);
   assign hit_p_now = hit_p_ff ||
                      (rd_valid_ff && rd_idx_ff < pu_ff && p_rdata == item_ff.tag);
   assign hit_sel   = item_ff.to_protect ? hit_p_now : hit_s_now;
   assign used_sel  = item_ff.to_protect ? pu_ff : su_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      rd_valid_in   = 1'b0;
      hit_s_in      = hit_s_ff;
      hit_p_in      = hit_p_ff;
      su_in         = su_ff;
      pu_in         = pu_ff;
      meta_in       = meta_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      s_we          = 1'b0;
      p_we          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               item_in  = q_head;
               cnt_in   = '0;
               hit_s_in = 1'b0;
               hit_p_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            hit_s_in = hit_s_now;
            hit_p_in = hit_p_now;
            if (cnt_ff < limit) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = cnt_ff;
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.strip_it = 1'b0;
            rsp_in.status   = STATUS_OK;
            if (item_ff.cls == CLS_INVALID) begin
               rsp_in.status = STATUS_INVALID;
            end else if (item_ff.query) begin
               case (item_ff.cls)
                  CLS_ANIM: rsp_in.strip_it = cfg.strip_animation;
                  CLS_META: rsp_in.strip_it = (cfg.strip_everything || meta_ff)
                                              && !cfg.protect_everything
                                              && (cfg.strip_everything || hit_s_now)
                                              && !hit_p_now;
                  default:  rsp_in.strip_it = 1'b0;
               endcase
            end else begin
               // A metadata tag named for stripping arms the flag even when
               // the set is full or already holds it.
               if (!item_ff.to_protect && item_ff.cls == CLS_META) begin
                  meta_in = 1'b1;
               end
               rsp_in.status = (item_ff.cls == CLS_META) ? STATUS_OK : STATUS_NOXFORM;
               if (!hit_sel) begin
                  if (used_sel == DEPTH_CNT) begin
                     rsp_in.status = STATUS_FULL;
                  end else if (item_ff.to_protect) begin
                     p_we  = 1'b1;
                     pu_in = pu_ff + CW'(1);
                  end else begin
                     s_we  = 1'b1;
                     su_in = su_ff + CW'(1);
                  end
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      cnt_ff    <= cnt_in;
      rd_idx_ff <= rd_idx_in;
      hit_s_ff  <= hit_s_in;
      hit_p_ff  <= hit_p_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         su_ff         <= '0;
         pu_ff         <= '0;
         meta_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         su_ff         <= su_in;
         pu_ff         <= pu_in;
         meta_ff       <= meta_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `CSF_ASSERT(a_counts_in_range, clock, reset, su_ff <= DEPTH_CNT && pu_ff <= DEPTH_CNT)
   `CSF_ASSERT(a_strobe_single, clock, reset, rsp_strobe_ff |=> !rsp_strobe_ff)
   `CSF_ASSERT(a_full_only_when_full, clock, reset,
      (rsp_strobe_ff && rsp_ff.status == STATUS_FULL) |-> (used_sel == DEPTH_CNT))

endmodule

FILE: design/chunk_strip_filter_unit.sv
// Chunk tag strip/protect filter. An item is taken when start is high and busy
// is low; its result appears on rsp_data for exactly one cycle with rsp_strobe,
// and the receiver cannot stall it. The lookup unit takes one item at a time:
// it pops the item from the queue, scans both tag sets, which sit in RAMs with
// one read port each, together one entry per cycle as far as the longer set,
// and then forms the result. A two-entry queue after the classifier lets
// two more items be taken while one is being looked up; busy is high while it
// is full. Configuration registers are written through the csr port, which is
// always ready, and should only be changed while no item is in flight.
module chunk_strip_filter_unit
   import csf_pkg::*;
   #(parameter int SET_DEPTH = 32)
   (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic       csr_wdata
   );

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      q_full;
   logic      q_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STRIP_EVERYTHING:   cfg_in.strip_everything   = csr_wdata;
            CSR_STRIP_ANIMATION:    cfg_in.strip_animation    = csr_wdata;
            CSR_PROTECT_EVERYTHING: cfg_in.protect_everything = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csf_front u_front (
      .start      (start),
      .req_data   (req_data),
      .q_full     (q_full),
      .busy       (busy),
      .push       (push),
      .push_entry (push_entry)
   );

   csf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   csf_back #(.SET_DEPTH(SET_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import csf_pkg::*;

   localparam int SET_DEPTH       = 32;
   localparam int LIMIT_CYCLES    = 1_000_000;
   localparam int ITEMS_PER_PHASE = 154;
   localparam int POOL_SIZE       = 48;
   // Three items in flight, each scanning a full set, plus some slack.
   localparam int TAIL_CYCLES     = 3 * (SET_DEPTH + 3) + 20;

   localparam logic [1:0] FN_ADD_STRIP   = 2'd0;
   localparam logic [1:0] FN_ADD_PROTECT = 2'd1;
   localparam logic [1:0] FN_QUERY       = 2'd2;
   localparam logic [1:0] FN_QUERY_ALT   = 2'd3;

   typedef struct packed {
      logic       set_cfg;
      cfg_type    cfg;
      req_type    req;
      logic       typed;
      rsp_type    rsp;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = CSR_STRIP_EVERYTHING;
   logic    csr_wdata = 1'b0;

   // Sideband for the item on the request port: a directed row may carry its own answer.
   logic    typed_now = 1'b0;
   rsp_type typed_rsp = '0;

   // Filter state as the testbench tracks it.
   logic [31:0] strip_set [SET_DEPTH];
   logic [31:0] protect_set [SET_DEPTH];
   int          strip_cnt;
   int          protect_cnt;
   logic        meta_named;
   cfg_type     cfg_now;

   rsp_type     answer_q [$];
   row_type     plan_q [$];
   logic [31:0] meta_pool [POOL_SIZE];

   int errors = 0;
   int cycles = 0;
   int n_items = 0;
   int n_results = 0;
   int n_stripped = 0;
   int n_full = 0;
   int n_noxform = 0;
   int n_invalid = 0;

   chunk_strip_filter_unit #(.SET_DEPTH(SET_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [1:0] tag_kind(logic [31:0] tag);
      logic       letters;
      logic [7:0] c;
      letters = 1'b1;
      for (int k = 0; k < 4; k++) begin
         c = tag[8*k +: 8];
         if (!((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) begin
            letters = 1'b0;
         end
      end
      if (!letters) return CLS_INVALID;
      if ((tag[31:24] >= 8'h41 && tag[31:24] <= 8'h5A) || tag == TAG_TRNS) return CLS_IMAGE;
      if (tag == TAG_ACTL || tag == TAG_FCTL || tag == TAG_FDAT) return CLS_ANIM;
      return CLS_META;
   endfunction

   function automatic logic set_holds(logic in_protect, logic [31:0] tag);
      int cnt;
      cnt = in_protect ? protect_cnt : strip_cnt;
      for (int i = 0; i < cnt; i++) begin
         if (in_protect ? (protect_set[i] == tag) : (strip_set[i] == tag)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the answer to one item and applies its effect on the sets and the metadata flag.
   function automatic rsp_type filter_predict(req_type r);
      rsp_type    res;
      logic [1:0] kind;
      logic       to_protect;
      int         cnt;
      kind = tag_kind(r.tag);
      res = {1'b0, STATUS_OK};
      if (r.func[1]) begin
         if (kind == CLS_INVALID) begin
            res.status = STATUS_INVALID;
         end else if (kind == CLS_ANIM) begin
            res.strip_it = cfg_now.strip_animation;
         end else if (kind == CLS_META) begin
            res.strip_it = (cfg_now.strip_everything || meta_named)
               && !cfg_now.protect_everything
               && (cfg_now.strip_everything || set_holds(1'b0, r.tag))
               && !set_holds(1'b1, r.tag);
         end
      end else if (kind == CLS_INVALID) begin
         res.status = STATUS_INVALID;
      end else begin
         to_protect = r.func[0];
         // A metadata tag named for stripping arms the flag even if it is not stored.
         if (!to_protect && kind == CLS_META) meta_named = 1'b1;
         res.status = (kind == CLS_META) ? STATUS_OK : STATUS_NOXFORM;
         if (!set_holds(to_protect, r.tag)) begin
            cnt = to_protect ? protect_cnt : strip_cnt;
            if (cnt >= SET_DEPTH) begin
               res.status = STATUS_FULL;
            end else if (to_protect) begin
               protect_set[protect_cnt] = r.tag;
               protect_cnt++;
            end else begin
               strip_set[strip_cnt] = r.tag;
               strip_cnt++;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Run stopped at the cycle limit.");
         $display("Mismatches found");
         $finish;
      end
      if (reset) begin
         strip_cnt   = 0;
         protect_cnt = 0;
         meta_named  = 1'b0;
         cfg_now     = '0;
      end else begin
         if (rsp_strobe) begin
            n_results++;
            if (answer_q.size() == 0) begin
               $error("result with no expectation: strip_it %0d status %0d",
                      rsp_data.strip_it, rsp_data.status);
               errors++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.strip_it !== want.strip_it) begin
                  $error("strip_it expected %0d actual %0d", want.strip_it, rsp_data.strip_it);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  errors++;
               end
            end
            if (rsp_data.strip_it === 1'b1) n_stripped++;
            if (rsp_data.status === STATUS_FULL) n_full++;
            if (rsp_data.status === STATUS_NOXFORM) n_noxform++;
            if (rsp_data.status === STATUS_INVALID) n_invalid++;
         end
         if (start && !busy) begin
            n_items++;
            pred = filter_predict(req_data);
            answer_q.push_back(typed_now ? typed_rsp : pred);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STRIP_EVERYTHING:   cfg_now.strip_everything   = csr_wdata;
               CSR_STRIP_ANIMATION:    cfg_now.strip_animation    = csr_wdata;
               CSR_PROTECT_EVERYTHING: cfg_now.protect_everything = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   task automatic send_item(req_type r, logic typed, rsp_type fixed);
      @(negedge clock);
      start     <= 1'b1;
      req_data  <= r;
      typed_now <= typed;
      typed_rsp <= fixed;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Holds the sender until every outstanding item has produced its result.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(cfg_type c);
      csr_write(CSR_STRIP_EVERYTHING, c.strip_everything);
      csr_write(CSR_STRIP_ANIMATION, c.strip_animation);
      csr_write(CSR_PROTECT_EVERYTHING, c.protect_everything);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic plan(logic set_cfg, cfg_type c, logic [1:0] f, logic [31:0] t,
                       logic typed, rsp_type r);
      row_type row;
      row.set_cfg = set_cfg;
      row.cfg     = c;
      row.req     = {f, t};
      row.typed   = typed;
      row.rsp     = r;
      plan_q.push_back(row);
   endtask

   function automatic logic [7:0] letter();
      logic [7:0] b;
      b = 8'($urandom_range(0, 25));
      return b + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
   endfunction

   function automatic logic [31:0] meta_word();
      logic [7:0] b;
      b = 8'h61 + 8'($urandom_range(0, 25));
      return {b, letter(), letter(), letter()};
   endfunction

   function automatic logic [31:0] pick_tag();
      logic [31:0] t;
      logic [7:0]  border;
      int          roll;
      int          pos;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         t = $urandom();
      end else if (roll < 25) begin
         // Letter tag with one byte moved to or just past a letter range boundary, or to 00 or FF.
         t = {letter(), letter(), letter(), letter()};
         pos = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: border = 8'h40;
            1: border = 8'h41;
            2: border = 8'h5A;
            3: border = 8'h5B;
            4: border = 8'h60;
            5: border = 8'h61;
            6: border = 8'h7A;
            7: border = 8'h7B;
            8: border = 8'h00;
            default: border = 8'hFF;
         endcase
         t[8*pos +: 8] = border;
      end else if (roll < 35) begin
         border = 8'h41 + 8'($urandom_range(0, 25));
         t = {border, letter(), letter(), letter()};
      end else if (roll < 43) begin
         case ($urandom_range(0, 3))
            0: t = TAG_TRNS;
            1: t = TAG_ACTL;
            2: t = TAG_FCTL;
            default: t = TAG_FDAT;
         endcase
      end else if (roll < 85) begin
         t = meta_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         t = meta_word();
      end
      return t;
   endfunction

   function automatic logic [1:0] pick_func();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return FN_ADD_STRIP;
      if (roll < 55) return FN_ADD_PROTECT;
      if (roll < 95) return FN_QUERY;
      return FN_QUERY_ALT;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   initial begin
      cfg_type phase_cfg [8];
      row_type row;
      logic    steady;
      req_type r;

      phase_cfg[0] = 3'b111;
      phase_cfg[1] = 3'b100;
      phase_cfg[2] = 3'b010;
      phase_cfg[3] = 3'b001;
      phase_cfg[4] = 3'b110;
      phase_cfg[5] = 3'b101;
      phase_cfg[6] = 3'b011;
      phase_cfg[7] = 3'b000;
      for (int i = 0; i < POOL_SIZE; i++) meta_pool[i] = meta_word();

      // Configuration bits are ordered strip_everything, strip_animation, protect_everything.
      plan(0, 3'b000, FN_QUERY,       32'h7A7A7A7A, 1, {1'b0, STATUS_OK});
      plan(1, 3'b100, FN_QUERY,       32'h7A7A7A7A, 0, '0);
      plan(1, 3'b101, FN_QUERY,       32'h7A7A7A7A, 1, {1'b0, STATUS_OK});
      plan(1, 3'b000, FN_QUERY,       32'h00000000, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_QUERY,       32'hFFFFFFFF, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_ADD_STRIP,   32'h40414141, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_ADD_STRIP,   32'h5B7A7A7A, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_ADD_PROTECT, 32'h617A7B61, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_QUERY_ALT,   32'h60616161, 1, {1'b0, STATUS_INVALID});
      plan(0, 3'b000, FN_ADD_STRIP,   32'h49484452, 1, {1'b0, STATUS_NOXFORM});
      plan(0, 3'b000, FN_ADD_PROTECT, TAG_TRNS,     1, {1'b0, STATUS_NOXFORM});
      plan(0, 3'b000, FN_ADD_STRIP,   TAG_ACTL,     1, {1'b0, STATUS_NOXFORM});
      plan(0, 3'b000, FN_QUERY,       TAG_ACTL,     1, {1'b0, STATUS_OK});
      plan(0, 3'b000, FN_QUERY,       TAG_TRNS,     1, {1'b0, STATUS_OK});
      plan(0, 3'b000, FN_QUERY,       32'h5A417A7A, 1, {1'b0, STATUS_OK});
      plan(0, 3'b000, FN_QUERY,       32'h41414141, 1, {1'b0, STATUS_OK});
      plan(0, 3'b000, FN_ADD_STRIP,   32'h74455874, 1, {1'b0, STATUS_OK});
      plan(0, 3'b000, FN_ADD_STRIP,   32'h74455874, 0, '0);
      plan(0, 3'b000, FN_QUERY,       32'h74455874, 0, '0);
      plan(0, 3'b000, FN_QUERY,       32'h7A545874, 0, '0);
      plan(0, 3'b000, FN_ADD_PROTECT, 32'h74455874, 0, '0);
      plan(0, 3'b000, FN_QUERY,       32'h74455874, 0, '0);
      plan(1, 3'b010, FN_QUERY_ALT,   TAG_FCTL,     0, '0);
      plan(0, 3'b010, FN_ADD_PROTECT, TAG_FDAT,     0, '0);
      plan(0, 3'b010, FN_QUERY,       TAG_FDAT,     0, '0);
      plan(0, 3'b010, FN_ADD_STRIP,   32'h7A7A7A7A, 0, '0);
      plan(0, 3'b010, FN_QUERY,       32'h7A7A7A7A, 0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0) begin
         row = plan_q.pop_front();
         if (row.set_cfg) begin
            drain();
            write_config(row.cfg);
         end
         send_item(row.req, row.typed, row.rsp);
      end

      for (int p = 0; p < 8; p++) begin
         drain();
         write_config(phase_cfg[p]);
         steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (!steady) idle_for(pick_gap());
            if ($urandom_range(0, 99) == 0) drain();
            r.func = pick_func();
            r.tag  = pick_tag();
            send_item(r, 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (answer_q.size() != 0) begin
         $error("%0d expected results never arrived", answer_q.size());
         errors++;
      end
      $display("Sent %0d tag items under 8 register settings plus the directed rows; %0d answers.",
               n_items, n_results);
      $display("Answers: %0d stripped, %0d set full, %0d untransformable, %0d invalid tag.",
               n_stripped, n_full, n_noxform, n_invalid);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
